### design/sqe_pkg.sv
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared sizes, request and status codes, and cell interface types for the
// sorted entry queue.
// ----------------------------------------------------------------------------
package sqe_pkg;

   // queue geometry
   localparam int DEPTH  = 128;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int KEY_W  = 16;
   localparam int REQ_W  = 2;
   localparam int STAT_W = 2;
   localparam int POS_W  = 7;
   localparam int OCC_W  = 8;

   // request codes
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   // cell update modes
   localparam logic [1:0] MODE_HOLD  = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_LEFT  = 2'd2;
   localparam logic [1:0] MODE_RIGHT = 2'd3;

   // command into one cell: update mode plus the request's key fields
   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key_id;
      logic [KEY_W-1:0] key_dur;
   } cell_cmd_type;

   // compare flags out of one cell
   typedef struct packed {
      logic le;
      logic hit;
   } cell_flag_type;

endpackage

### design/sqe_cell.sv
// ----------------------------------------------------------------------------
// sqe_cell
// One queue slot: holds an id and a duration, compares them against the
// request key and loads from the request or from either neighbour.
// ----------------------------------------------------------------------------
module sqe_cell
   import sqe_pkg::*;
(
   input  logic             clock,
   input  logic             occupied,
   input  cell_cmd_type     cmd,
   input  logic [KEY_W-1:0] left_id,
   input  logic [KEY_W-1:0] left_dur,
   input  logic [KEY_W-1:0] right_id,
   input  logic [KEY_W-1:0] right_dur,
   output logic [KEY_W-1:0] cell_id,
   output logic [KEY_W-1:0] cell_dur,
   output cell_flag_type    flags
);

   logic [KEY_W-1:0] id_ff;
   logic [KEY_W-1:0] id_in;
   logic [KEY_W-1:0] dur_ff;
   logic [KEY_W-1:0] dur_in;

   // next contents
   always_comb begin
      unique case (cmd.mode)
         MODE_LOAD: begin
            id_in  = cmd.key_id;
            dur_in = cmd.key_dur;
         end
         MODE_LEFT: begin
            id_in  = left_id;
            dur_in = left_dur;
         end
         MODE_RIGHT: begin
            id_in  = right_id;
            dur_in = right_dur;
         end
         default: begin
            id_in  = id_ff;
            dur_in = dur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      dur_ff <= dur_in;
   end

   assign cell_id   = id_ff;
   assign cell_dur  = dur_ff;
   assign flags.le  = occupied && (dur_ff <= cmd.key_dur);
   assign flags.hit = occupied && (id_ff == cmd.key_id);

endmodule

### design/sqe_scan.sv
// ----------------------------------------------------------------------------
// sqe_scan
// First-set search across the cell row: log-depth prefix or, one-hot of the
// first set flag and its encoded position.
// ----------------------------------------------------------------------------
module sqe_scan
   import sqe_pkg::*;
(
   input  logic [DEPTH-1:0] vec,
   output logic [DEPTH-1:0] past_first,
   output logic [DEPTH-1:0] first,
   output logic             any,
   output logic [IDX_W-1:0] index
);

   logic [DEPTH-1:0] pre;

   // inclusive prefix or, doubling span each level
   always_comb begin
      pre = vec;
      for (int s = 0; s < IDX_W; s++) begin
         pre = pre | (pre << (1 << s));
      end
   end

   assign past_first = pre << 1;
   assign first      = vec & ~past_first;
   assign any        = pre[DEPTH-1];

   // one-hot to binary
   always_comb begin
      index = '0;
      for (int i = 0; i < DEPTH; i++) begin
         index = index | (first[i] ? IDX_W'(i) : IDX_W'(0));
      end
   end

endmodule

### design/sorted_entry_queue.sv
// ----------------------------------------------------------------------------
// sorted_entry_queue
// Bounded queue of id/duration entries held in a shift row of cells, with
// append, sorted insert, head removal and id search.
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid/req_ready): req_type selects append, insert
//   by duration, remove head or search by id; req_entry_id and
//   req_entry_duration carry the entry or the search key
//   response channel (rsp_valid/rsp_ready): exactly one response per
//   request, with status, removed head entry, match position and the
//   occupancy after the request
//   every request is executed by the whole cell row in the cycle of its
//   transfer; the response sits in the output register from the next cycle,
//   and one request per cycle is sustained while rsp_ready stays high
//   the rate is set by the row update in the transfer cycle: compare in every cell,
//   a prefix-or scan over the row, and a neighbour shift into each cell
//   a stalled response keeps req_ready low only while the output register
//   is full and rsp_ready is low; the queue contents are untouched then
//   reset clears the entry count and the response valid flag; cell contents
//   are left as they are and are never read below an empty count
// ----------------------------------------------------------------------------
module sorted_entry_queue
   import sqe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [KEY_W-1:0]  req_entry_id,
   input  logic [KEY_W-1:0]  req_entry_duration,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [KEY_W-1:0]  rsp_out_id,
   output logic [KEY_W-1:0]  rsp_out_duration,
   output logic [POS_W-1:0]  rsp_position,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   // entry count and output register
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [STAT_W-1:0] status_ff;
   logic [STAT_W-1:0] status_in;
   logic [KEY_W-1:0]  out_id_ff;
   logic [KEY_W-1:0]  out_id_in;
   logic [KEY_W-1:0]  out_dur_ff;
   logic [KEY_W-1:0]  out_dur_in;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;

   logic req_fire;
   logic full;
   logic empty;
   logic add_go;
   logic remove_go;

   // cell row
   logic [KEY_W-1:0]  row_id  [DEPTH];
   logic [KEY_W-1:0]  row_dur [DEPTH];
   cell_flag_type     row_flag [DEPTH];
   cell_cmd_type      row_cmd  [DEPTH];
   logic [DEPTH-1:0]  occ;
   logic [DEPTH-1:0]  le_vec;
   logic [DEPTH-1:0]  hit_vec;

   // scan
   logic [DEPTH-1:0]  scan_vec;
   logic [DEPTH-1:0]  scan_past;
   logic [DEPTH-1:0]  scan_first;
   logic              scan_any;
   logic [IDX_W-1:0]  scan_index;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign add_go    = req_fire && !full
                      && ((req_type == REQ_APPEND) || (req_type == REQ_INSERT));
   assign remove_go = req_fire && !empty && (req_type == REQ_REMOVE);

   // per-cell occupancy, flags and update mode
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] left_id;
      logic [KEY_W-1:0] left_dur;
      logic [KEY_W-1:0] right_id;
      logic [KEY_W-1:0] right_dur;

      assign occ[i]     = (CNT_W'(i) < count_ff);
      assign le_vec[i]  = row_flag[i].le;
      assign hit_vec[i] = row_flag[i].hit;

      // head has no left neighbour, tail keeps its own value on a shift
      if (i == 0) begin : g_head
         assign left_id  = req_entry_id;
         assign left_dur = req_entry_duration;
      end else begin : g_body_l
         assign left_id  = row_id[i-1];
         assign left_dur = row_dur[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_id  = row_id[i];
         assign right_dur = row_dur[i];
      end else begin : g_body_r
         assign right_id  = row_id[i+1];
         assign right_dur = row_dur[i+1];
      end

      always_comb begin
         row_cmd[i].key_id  = req_entry_id;
         row_cmd[i].key_dur = req_entry_duration;
         priority if (add_go && scan_first[i]) begin
            row_cmd[i].mode = MODE_LOAD;
         end else if (add_go && scan_past[i]) begin
            row_cmd[i].mode = MODE_LEFT;
         end else if (remove_go) begin
            row_cmd[i].mode = MODE_RIGHT;
         end else begin
            row_cmd[i].mode = MODE_HOLD;
         end
      end

      sqe_cell u_cell (
         .clock     (clock),
         .occupied  (occ[i]),
         .cmd       (row_cmd[i]),
         .left_id   (left_id),
         .left_dur  (left_dur),
         .right_id  (right_id),
         .right_dur (right_dur),
         .cell_id   (row_id[i]),
         .cell_dur  (row_dur[i]),
         .flags     (row_flag[i])
      );
   end

   // one shared scan: append looks for the first free cell, insert for the
   // first free or larger-duration cell, search for the first id match
   always_comb begin
      unique case (req_type)
         REQ_APPEND: scan_vec = ~occ;
         REQ_INSERT: scan_vec = ~le_vec;
         REQ_REMOVE: scan_vec = hit_vec;
         REQ_SEARCH: scan_vec = hit_vec;
         default:    scan_vec = hit_vec;
      endcase
   end

   sqe_scan u_scan (
      .vec        (scan_vec),
      .past_first (scan_past),
      .first      (scan_first),
      .any        (scan_any),
      .index      (scan_index)
   );

   // response and count update
   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      out_id_in  = out_id_ff;
      out_dur_in = out_dur_ff;
      pos_in     = pos_ff;
      if (req_fire) begin
         status_in  = ST_OK;
         out_id_in  = '0;
         out_dur_in = '0;
         pos_in     = '0;
         unique case (req_type)
            REQ_APPEND, REQ_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_REMOVE: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  out_id_in  = row_id[0];
                  out_dur_in = row_dur[0];
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            default: begin
               if (scan_any) begin
                  pos_in = POS_W'(scan_index);
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end
         endcase
      end
   end

   // response valid: set on a request transfer, cleared on a response transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_id_ff  <= out_id_in;
      out_dur_ff <= out_dur_in;
      pos_ff     <= pos_in;
   end

   logic [OCC_W-1:0] occ_ff;
   always_ff @(posedge clock) begin
      occ_ff <= OCC_W'(count_in);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_duration = out_dur_ff;
   assign rsp_position     = pos_ff;
   assign rsp_occupancy    = occ_ff;

   // count never runs past the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // at most one cell is chosen by the scan
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(scan_first))
      else $error("scan selected more than one cell");

   // an add to a full queue reports full and leaves the count alone
   a_full_add: assert property (@(posedge clock) disable iff (reset)
      (req_fire && full && ((req_type == REQ_APPEND) || (req_type == REQ_INSERT)))
      |=> (rsp_status == ST_FULL) && $stable(count_ff))
      else $error("add to full queue not rejected");

   // removal from a non-empty queue drops the count by one
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      remove_go |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not decrement count");

   // count only moves on a request transfer
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a transfer");

endmodule
